### design/cau_pkg.sv
// Shared types, codes and saturation helper for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int DATA_W      = 32;
  localparam int PROD_W      = 64;
  localparam int WIDE_W      = 96;
  localparam int STEPS       = 32;
  localparam int MODE_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [MODE_W-1:0] MODE_ADD   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MUL   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIV   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CONJ  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MOD   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DIVR  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SCALE = 4'd7;
  localparam logic [MODE_W-1:0] MODE_EQ    = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic [3:0] {
    K_NONE, K_ADD, K_SUB, K_MUL, K_DIV, K_CONJ, K_MOD, K_DIVR, K_SCALE, K_EQ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               divz;
    logic [DATA_W-1:0]  a_re;
    logic [DATA_W-1:0]  a_im;
    logic [DATA_W-1:0]  b_re;
    logic [DATA_W-1:0]  b_im;
  } op_t;

  typedef struct packed {
    logic               sat;
    logic [DATA_W-1:0]  val;
  } sat_t;

  typedef struct packed {
    logic [WIDE_W-1:0]  rem;
    logic [DATA_W-1:0]  q;
    logic               neg;
    logic               ovf;
  } lane_t;

  typedef struct packed {
    kind_t              kind;
    logic               divz;
    logic [PROD_W-1:0]  den;
    lane_t              re;
    lane_t              im;
    logic [DATA_W-1:0]  pre_re;
    logic [DATA_W-1:0]  pre_im;
    logic               pre_sat;
    logic               eq;
  } stg_t;

  // clamp a wide two's complement value to 32 bits
  function automatic sat_t sat32(input logic [WIDE_W-1:0] v);
    sat_t r;
    r.sat = !((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]));
    if (r.sat) begin
      r.val = v[WIDE_W-1] ? NEG_MAX : POS_MAX;
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/cau_front.sv
// Front end: takes input transfers, decodes the mode and flags zero divisors.
`default_nettype none
module cau_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cau_pkg::MODE_W-1:0]    mode,
  input  wire logic [cau_pkg::DATA_W-1:0]    a_re,
  input  wire logic [cau_pkg::DATA_W-1:0]    a_im,
  input  wire logic [cau_pkg::DATA_W-1:0]    b_re,
  input  wire logic [cau_pkg::DATA_W-1:0]    b_im,
  output logic                               push,
  output cau_pkg::op_t                       push_op,
  input  wire logic                          q_full
);

  logic         fr_valid;
  logic         fr_valid_next;
  cau_pkg::op_t fr_op;
  cau_pkg::op_t dec_op;
  logic         accept;

  assign in_stall = fr_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid && !q_full;
  assign push_op  = fr_op;
  assign fr_valid_next = (fr_valid && !push) || accept;

  always_comb begin
    dec_op      = '0;
    dec_op.a_re = a_re;
    dec_op.a_im = a_im;
    dec_op.b_re = b_re;
    dec_op.b_im = b_im;
    unique case (mode)
      cau_pkg::MODE_ADD:   dec_op.kind = cau_pkg::K_ADD;
      cau_pkg::MODE_SUB:   dec_op.kind = cau_pkg::K_SUB;
      cau_pkg::MODE_MUL:   dec_op.kind = cau_pkg::K_MUL;
      cau_pkg::MODE_DIV: begin
        dec_op.kind = cau_pkg::K_DIV;
        dec_op.divz = (b_re == '0) && (b_im == '0);
      end
      cau_pkg::MODE_CONJ:  dec_op.kind = cau_pkg::K_CONJ;
      cau_pkg::MODE_MOD:   dec_op.kind = cau_pkg::K_MOD;
      cau_pkg::MODE_DIVR: begin
        dec_op.kind = cau_pkg::K_DIVR;
        dec_op.divz = (b_re == '0);
      end
      cau_pkg::MODE_SCALE: dec_op.kind = cau_pkg::K_SCALE;
      cau_pkg::MODE_EQ:    dec_op.kind = cau_pkg::K_EQ;
      default:             dec_op.kind = cau_pkg::K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_op <= dec_op;
    end
  end

endmodule
`default_nettype wire

### design/cau_queue.sv
// Short queue of decoded operations between the front end and the datapath.
`default_nettype none
module cau_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cau_pkg::op_t  push_op,
  output logic               full,
  input  wire logic          pop,
  output cau_pkg::op_t       head,
  output logic               empty
);

  cau_pkg::op_t                   entries [cau_pkg::QUEUE_DEPTH];
  logic [cau_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cau_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cau_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == cau_pkg::QCNT_W'(cau_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule
`default_nettype wire

### design/cau_back.sv
// Datapath: products, operand setup, 32 divide/root bit stages, result packing.
`default_nettype none
module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cau_pkg::op_t                   head,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cau_pkg::DATA_W-1:0]          res_re,
  output logic [cau_pkg::DATA_W-1:0]          res_im,
  output logic                                is_equal,
  output logic [cau_pkg::STATUS_W-1:0]        status
);

  localparam int DW = cau_pkg::DATA_W;
  localparam int PW = cau_pkg::PROD_W;
  localparam int WW = cau_pkg::WIDE_W;
  localparam int NS = cau_pkg::STEPS;

  function automatic logic [WW-1:0] sx_d(input logic [DW-1:0] v);
    return {{(WW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [WW-1:0] sx_p(input logic [PW-1:0] v);
    return {{(WW-PW){v[PW-1]}}, v};
  endfunction

  // one restoring division bit
  function automatic cau_pkg::lane_t div_step(input cau_pkg::lane_t l,
                                               input logic [PW-1:0] den, input int k);
    cau_pkg::lane_t    n;
    logic [WW-1:0]     cand;
    n    = l;
    cand = {{(WW-PW){1'b0}}, den} << k;
    if (l.rem >= cand) begin
      n.rem = l.rem - cand;
      n.q   = l.q | (DW'(1) << k);
    end
    return n;
  endfunction

  // one square root bit: (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
  function automatic cau_pkg::lane_t sqrt_step(input cau_pkg::lane_t l, input int k);
    cau_pkg::lane_t    n;
    logic [WW-1:0]     cand;
    n    = l;
    cand = ({{(WW-DW){1'b0}}, l.q} << (k + 1)) + (WW'(1) << (2 * k));
    if (l.rem >= cand) begin
      n.rem = l.rem - cand;
      n.q   = l.q | (DW'(1) << k);
    end
    return n;
  endfunction

  function automatic cau_pkg::stg_t run_step(input cau_pkg::stg_t s, input int k);
    cau_pkg::stg_t n;
    n = s;
    if (s.kind == cau_pkg::K_MOD) begin
      n.re = sqrt_step(s.re, k);
    end else begin
      n.re = div_step(s.re, s.den, k);
    end
    n.im = div_step(s.im, s.den, k);
    return n;
  endfunction

  function automatic cau_pkg::sat_t pack_lane(input cau_pkg::lane_t l);
    cau_pkg::sat_t r;
    logic [WW-1:0] mag;
    mag = {{(WW-DW){1'b0}}, l.q};
    if (l.ovf) begin
      r.sat = 1'b1;
      r.val = l.neg ? cau_pkg::NEG_MAX : cau_pkg::POS_MAX;
    end else begin
      r = cau_pkg::sat32(l.neg ? (WW'(0) - mag) : mag);
    end
    return r;
  endfunction

  logic en;

  // product stage
  logic                p1_valid;
  cau_pkg::op_t        p1_op;
  logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
  logic signed [DW-1:0] y0, y1;

  // setup stage inputs
  cau_pkg::stg_t       p2;
  logic signed [WW-1:0] m0_w, m1_w, m2_w, m3_w, m4_w, m5_w;
  logic signed [WW-1:0] ar_w, ai_w, br_w, bi_w;
  logic signed [WW-1:0] mul_re_w, mul_im_w, scl_re_w, scl_im_w;
  logic signed [WW-1:0] num_re, num_im, abs_ar, abs_ai, abs_br;
  logic [PW-1:0]        n_re, n_im, den;
  logic                 neg_re, neg_im;
  cau_pkg::sat_t        s_re, s_im;

  cau_pkg::stg_t        stg [NS+1];
  logic [NS:0]          sv;

  cau_pkg::stg_t        fin;
  cau_pkg::sat_t        f_re, f_im;

  assign en    = !(out_valid && out_stall);
  assign q_pop = en && !q_empty;

  assign y0 = (head.kind == cau_pkg::K_MOD) ? head.a_re : head.b_re;
  assign y1 = (head.kind == cau_pkg::K_MOD) ? head.a_im : head.b_im;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op <= head;
      m0    <= $signed(head.a_re) * y0;
      m1    <= $signed(head.a_im) * y1;
      m2    <= $signed(head.a_re) * $signed(head.b_im);
      m3    <= $signed(head.a_im) * $signed(head.b_re);
      m4    <= $signed(head.b_re) * $signed(head.b_re);
      m5    <= $signed(head.b_im) * $signed(head.b_im);
    end
  end

  always_comb begin
    m0_w = sx_p(m0);
    m1_w = sx_p(m1);
    m2_w = sx_p(m2);
    m3_w = sx_p(m3);
    m4_w = sx_p(m4);
    m5_w = sx_p(m5);
    ar_w = sx_d(p1_op.a_re);
    ai_w = sx_d(p1_op.a_im);
    br_w = sx_d(p1_op.b_re);
    bi_w = sx_d(p1_op.b_im);

    // arithmetic shift right rounds toward minus infinity
    mul_re_w = (m0_w - m1_w) >>> FRAC_BITS;
    mul_im_w = (m2_w + m3_w) >>> FRAC_BITS;
    scl_re_w = m0_w >>> FRAC_BITS;
    scl_im_w = m3_w >>> FRAC_BITS;

    num_re = m0_w + m1_w;
    num_im = m3_w - m2_w;
    abs_ar = ar_w[WW-1] ? -ar_w : ar_w;
    abs_ai = ai_w[WW-1] ? -ai_w : ai_w;
    abs_br = br_w[WW-1] ? -br_w : br_w;

    if (p1_op.kind == cau_pkg::K_DIVR) begin
      n_re   = abs_ar[PW-1:0];
      n_im   = abs_ai[PW-1:0];
      den    = abs_br[PW-1:0];
      neg_re = p1_op.a_re[DW-1] ^ p1_op.b_re[DW-1];
      neg_im = p1_op.a_im[DW-1] ^ p1_op.b_re[DW-1];
    end else begin
      n_re   = num_re[WW-1] ? PW'(-num_re) : num_re[PW-1:0];
      n_im   = num_im[WW-1] ? PW'(-num_im) : num_im[PW-1:0];
      den    = m4[PW-1:0] + m5[PW-1:0];
      neg_re = num_re[WW-1];
      neg_im = num_im[WW-1];
    end

    case (p1_op.kind)
      cau_pkg::K_ADD: begin
        s_re = cau_pkg::sat32(ar_w + br_w);
        s_im = cau_pkg::sat32(ai_w + bi_w);
      end
      cau_pkg::K_SUB: begin
        s_re = cau_pkg::sat32(ar_w - br_w);
        s_im = cau_pkg::sat32(ai_w - bi_w);
      end
      cau_pkg::K_MUL: begin
        s_re = cau_pkg::sat32(mul_re_w);
        s_im = cau_pkg::sat32(mul_im_w);
      end
      cau_pkg::K_SCALE: begin
        s_re = cau_pkg::sat32(scl_re_w);
        s_im = cau_pkg::sat32(scl_im_w);
      end
      cau_pkg::K_CONJ: begin
        s_re = cau_pkg::sat32(ar_w);
        s_im = cau_pkg::sat32(-ai_w);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase

    p2         = '0;
    p2.kind    = p1_op.kind;
    p2.divz    = p1_op.divz;
    p2.den     = den;
    p2.pre_re  = s_re.val;
    p2.pre_im  = s_im.val;
    p2.pre_sat = s_re.sat || s_im.sat;
    p2.eq      = (p1_op.kind == cau_pkg::K_EQ) &&
                 (p1_op.a_re == p1_op.b_re) && (p1_op.a_im == p1_op.b_im);
    p2.re.neg  = neg_re;
    p2.im.neg  = neg_im;
    p2.re.ovf  = {{(WW-PW){1'b0}}, n_re} >=
                 ({{(WW-PW){1'b0}}, den} << (DW - FRAC_BITS));
    p2.im.ovf  = {{(WW-PW){1'b0}}, n_im} >=
                 ({{(WW-PW){1'b0}}, den} << (DW - FRAC_BITS));
    p2.im.rem  = {{(WW-PW){1'b0}}, n_im} << FRAC_BITS;
    if (p1_op.kind == cau_pkg::K_MOD) begin
      // radicand is a sum of squares, never negative
      p2.re.rem = {{(WW-PW){1'b0}}, m0[PW-1:0] + m1[PW-1:0]};
    end else begin
      p2.re.rem = {{(WW-PW){1'b0}}, n_re} << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= !q_empty;
      sv        <= {sv[NS-1:0], p1_valid};
      out_valid <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= p2;
      for (int i = 1; i <= NS; i++) begin
        stg[i] <= run_step(stg[i-1], NS - i);
      end
    end
  end

  assign fin = stg[NS];

  always_comb begin
    f_re = pack_lane(fin.re);
    f_im = pack_lane(fin.im);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_equal <= fin.eq;
      case (fin.kind) inside
        cau_pkg::K_DIV, cau_pkg::K_DIVR: begin
          if (fin.divz) begin
            res_re <= '0;
            res_im <= '0;
            status <= cau_pkg::ST_DIVZ;
          end else begin
            res_re <= f_re.val;
            res_im <= f_im.val;
            status <= (f_re.sat || f_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
          end
        end
        cau_pkg::K_MOD: begin
          res_re <= fin.re.q[DW-1] ? cau_pkg::POS_MAX : fin.re.q;
          res_im <= '0;
          status <= fin.re.q[DW-1] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        default: begin
          res_re <= fin.pre_re;
          res_im <= fin.pre_im;
          status <= fin.pre_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### design/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front end, operation queue and datapath.
//
// Takes one operation per clock and delivers one result per clock when the
// output side does not stall. Each operation goes through the input
// register, a four-entry queue, a product stage, an operand setup stage,
// 32 restoring bit stages (shared by the divide and square root paths) and
// the output register. Throughput is one transfer per cycle when the output
// side does not stall.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cau_pkg::MODE_W-1:0]    mode,
  input  wire logic [cau_pkg::DATA_W-1:0]    a_re,
  input  wire logic [cau_pkg::DATA_W-1:0]    a_im,
  input  wire logic [cau_pkg::DATA_W-1:0]    b_re,
  input  wire logic [cau_pkg::DATA_W-1:0]    b_im,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cau_pkg::DATA_W-1:0]         res_re,
  output logic [cau_pkg::DATA_W-1:0]         res_im,
  output logic                               is_equal,
  output logic [cau_pkg::STATUS_W-1:0]       status
);

  logic         push;
  cau_pkg::op_t push_op;
  logic         q_full;
  logic         q_pop;
  cau_pkg::op_t head;
  logic         q_empty;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (head),
    .empty   (q_empty)
  );

  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .is_equal  (is_equal),
    .status    (status)
  );

endmodule
`default_nettype wire

### tb/sv/complex_arithmetic_unit_test.sv
// Testbench for the complex arithmetic unit: directed and random operations, scoreboard check.
module complex_arithmetic_unit_test;

  localparam int FRAC = 16;
  localparam int NUM_RANDOM = 930;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [3:0] mode;
    logic [31:0] a_re, a_im, b_re, b_im;
  } operation_t;

  typedef struct {
    logic [31:0] re, im;
    logic eq;
    logic [1:0] st;
  } cplx_result_t;

  // Positive magnitude to a saturated 32-bit pattern; negative sign applied.
  function automatic logic [31:0] clamp32(input logic is_neg, input logic [127:0] mag,
                                          inout logic sat);
    if (!is_neg) begin
      if (mag > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 128'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'h0 - mag[31:0];
  endfunction

  function automatic logic [127:0] abs128(input logic signed [127:0] x);
    return x < 0 ? -x : x;
  endfunction

  // Signed value narrowed by floor shift, then clamped.
  function automatic logic [31:0] shift_floor(input logic signed [127:0] v, inout logic sat);
    logic signed [127:0] q;
    q = v >>> FRAC;
    return clamp32(q < 0, abs128(q), sat);
  endfunction

  // Truncated fixed point quotient of signed numerator by positive denominator.
  function automatic logic [31:0] trunc_div(input logic signed [127:0] n,
                                            input logic [127:0] d, inout logic sat);
    logic [127:0] q;
    q = (abs128(n) << FRAC) / d;
    return clamp32(n < 0, q, sat);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, b;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic cplx_result_t compute_complex(input operation_t op);
    cplx_result_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    logic sat;
    ar = $signed(op.a_re); ai = $signed(op.a_im);
    br = $signed(op.b_re); bi = $signed(op.b_im);
    r = '{re: 0, im: 0, eq: 0, st: cau_pkg::ST_OK};
    sat = 1'b0;
    case (op.mode)
      cau_pkg::MODE_ADD: begin
        r.re = clamp32(ar + br < 0, abs128(ar + br), sat);
        r.im = clamp32(ai + bi < 0, abs128(ai + bi), sat);
      end
      cau_pkg::MODE_SUB: begin
        r.re = clamp32(ar - br < 0, abs128(ar - br), sat);
        r.im = clamp32(ai - bi < 0, abs128(ai - bi), sat);
      end
      cau_pkg::MODE_MUL: begin
        r.re = shift_floor(ar * br - ai * bi, sat);
        r.im = shift_floor(ar * bi + ai * br, sat);
      end
      cau_pkg::MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = cau_pkg::ST_DIVZ;
        else begin
          r.re = trunc_div(ar * br + ai * bi, den, sat);
          r.im = trunc_div(ai * br - ar * bi, den, sat);
        end
      end
      cau_pkg::MODE_CONJ: begin
        r.re = op.a_re;
        r.im = clamp32(ai > 0, abs128(ai), sat);
      end
      cau_pkg::MODE_MOD: r.re = clamp32(1'b0, floor_sqrt(ar * ar + ai * ai), sat);
      cau_pkg::MODE_DIVR: begin
        if (br == 0) r.st = cau_pkg::ST_DIVZ;
        else begin
          r.re = trunc_div(br < 0 ? -ar : ar, abs128(br), sat);
          r.im = trunc_div(br < 0 ? -ai : ai, abs128(br), sat);
        end
      end
      cau_pkg::MODE_SCALE: begin
        r.re = shift_floor(ar * br, sat);
        r.im = shift_floor(ai * br, sat);
      end
      cau_pkg::MODE_EQ: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    if (r.st == cau_pkg::ST_OK && sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  class result_board;
    cplx_result_t pending[$];
    int mismatches = 0;

    function void note_operation(operation_t op);
      pending.push_back(compute_complex(op));
    endfunction

    function void check_result(cplx_result_t got);
      cplx_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%h im=%h", got.re, got.im);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re || got.im !== want.im || got.eq !== want.eq ||
          got.st !== want.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected re=%h im=%h eq=%b st=%0d, got re=%h im=%h eq=%b st=%0d",
                   want.re, want.im, want.eq, want.st, got.re, got.im, got.eq, got.st);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] mode = '0;
  logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] res_re, res_im;
  logic is_equal;
  logic [1:0] status;

  result_board board = new();
  operation_t directed_ops[$];
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check results and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_result('{re: res_re, im: res_im, eq: is_equal, st: status});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver stall pattern: each cycle draws no stall, light random stall or heavy stall; forced on during long_hold.
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else case (($urandom_range(0, 2) + ($time / 12000)) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one operation and hold it until transferred.
  task automatic send_operation(operation_t op);
    in_valid <= 1'b1;
    mode <= op.mode; a_re <= op.a_re; a_im <= op.a_im; b_re <= op.b_re; b_im <= op.b_im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operation(op);
  endtask

  task automatic drop_valid_for(int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Hold off the receiver long enough for the block to fill and stall its input.
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    long_hold = 1'b1;
    repeat (150) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    operation_t op;
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int m = 0; m < 16; m++)
      directed_ops.push_back('{m[3:0], 32'h0003_0000, 32'hFFFE_8000, 32'h0001_4000, 32'h0000_C000});
    directed_ops.push_back('{cau_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000});
    directed_ops.push_back('{cau_pkg::MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000});
    directed_ops.push_back('{cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF});
    directed_ops.push_back('{cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0});
    directed_ops.push_back('{cau_pkg::MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1});
    directed_ops.push_back('{cau_pkg::MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0});
    directed_ops.push_back('{cau_pkg::MODE_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0});
    directed_ops.push_back('{cau_pkg::MODE_DIVR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h5});
    directed_ops.push_back('{cau_pkg::MODE_DIVR, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF, 32'h5});
    directed_ops.push_back('{cau_pkg::MODE_EQ, 32'h1234_5678, 32'h8000_0000,
                             32'h1234_5678, 32'h8000_0000});
    foreach (directed_ops[i]) send_operation(directed_ops[i]);
    drain_results();

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        op.mode = 4'(($urandom_range(0, 19) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8));
        op.a_re = rand_word(); op.a_im = rand_word();
        op.b_re = rand_word(); op.b_im = rand_word();
        if (op.mode == cau_pkg::MODE_EQ && $urandom_range(0, 1)) begin
          op.b_re = op.a_re;
          if ($urandom_range(0, 2) != 0) op.b_im = op.a_im;
        end
        send_operation(op);
      end
      if (n == NUM_RANDOM / 2) drain_results();
      else drop_valid_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
    drain_results();
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### complex_arithmetic_unit.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_queue.sv
design/cau_back.sv
design/complex_arithmetic_unit.sv
tb/sv/complex_arithmetic_unit_test.sv
